@@ sv/assert_macros.svh @@
// Assertion helpers included by the decoder unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ sv/ccsd_pkg.sv @@
package ccsd_pkg;

  localparam int ColorW         = 8;
  localparam int SymbolW        = 2;
  localparam int PaletteSize    = 4;
  localparam int DistW          = 18;
  localparam int ScoreW         = 6;
  localparam int ByteW          = 8;
  localparam int CfgIdxW        = 2;
  localparam int CfgDataW       = 24;
  localparam int HeaderBytesDef = 5;
  localparam int HeaderDepth    = 8;

  // Fixed frame header; entries past the fifth byte are zero.
  localparam logic [ByteW-1:0] HeaderTable [HeaderDepth] = '{
    8'h43, 8'h4D, 8'h41, 8'h43, 8'h01, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } color_t;

  typedef logic [SymbolW-1:0] symbol_t;
  typedef color_t palette_t [PaletteSize];

  typedef enum logic [CfgIdxW-1:0] {
    REG_PALETTE_ZERO  = 2'd0,
    REG_PALETTE_ONE   = 2'd1,
    REG_PALETTE_TWO   = 2'd2,
    REG_PALETTE_THREE = 2'd3
  } cfg_reg_e;

  // Result fields, first field in the highest bits.
  typedef struct packed {
    logic              header_complete;
    logic [ScoreW-1:0] header_score;
    logic [ByteW-1:0]  packed_byte;
    symbol_t           cell_symbol;
  } result_t;

endpackage

@@ sv/color_cell_symbol_decoder_unit.sv @@
// Cell color symbol decoder.
//
// The input channel carries one cell's mean color per transfer: in_tdata holds
// blue, green and red, and in_tuser marks the first cell of a frame. Each cell
// is matched to the nearest of four palette colors (squared distance, lowest
// index on a tie). Symbols are packed four to a byte, the first one in bits 7
// to 6, and every fourth cell also carries the finished byte. The first bytes
// of a frame are compared with a fixed header and the differing bits are summed.
// Exactly one result transfer leaves for every input transfer, in order.
// An item is captured in the input register, and the classification and packer
// update run in one pass into the result register. Throughput is one item per
// cycle unless the receiver stalls; the single-pass distance compare sets it.
// When the receiver stalls, the result register holds and the input register
// still takes one more item before in_tready drops. Reset clears both stages,
// the packer, the score and the palette. The user must write the palette
// through the cfg port while no item is in flight; the block does not enforce it.

`include "assert_macros.svh"

module color_cell_symbol_decoder_unit import ccsd_pkg::*; #(
  parameter int HEADER_BYTES = HeaderBytesDef
) (
  input  logic                clk,
  input  logic                rst_n,
  // Input stream.
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [23:0]         in_tdata,   // cell_blue[7:0], cell_green[15:8], cell_red[23:16]
  input  logic                in_tuser,   // frame_start
  // Result stream.
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [23:0]         out_tdata,  // cell_symbol[1:0], packed_byte[9:2],
                                          // header_score[15:10], header_complete[16], zero
  output logic                out_tuser,  // byte_ready
  // Configuration writes.
  input  logic                cfg_wr_en,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam int CntW     = $clog2(HEADER_BYTES + 1);
  localparam int PhaseW   = 2;
  localparam int ShiftW   = ByteW - SymbolW;
  localparam int OnesW    = $clog2(ByteW + 1);
  localparam int SumW     = ScoreW + 1;
  localparam int OutPadW  = 24 - $bits(result_t);

  // Palette registers.
  palette_t palette_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PaletteSize; k++) begin
        palette_r[k] <= '0;
      end
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PALETTE_ZERO:  palette_r[0] <= cfg_data;
        REG_PALETTE_ONE:   palette_r[1] <= cfg_data;
        REG_PALETTE_TWO:   palette_r[2] <= cfg_data;
        REG_PALETTE_THREE: palette_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: the result register loads when empty or being drained, and the
  // input register loads when empty or moving into the result register.
  logic s1_valid_r;
  logic out_valid_r;
  logic out_load;
  logic s1_advance;
  logic in_fire;

  assign out_load   = !out_valid_r || out_tready;
  assign s1_advance = s1_valid_r && out_load;
  assign in_tready  = !s1_valid_r || out_load;
  assign in_fire    = in_tvalid && in_tready;

  color_t s1_color_r;
  logic   s1_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_color_r <= in_tdata;
      s1_start_r <= in_tuser;
    end
  end

  // Nearest palette entry for the captured cell.
  symbol_t sym;

  ccsd_nearest u_nearest (
    .color   (s1_color_r),
    .palette (palette_r),
    .symbol  (sym)
  );

  // Packer and header scorer state.
  logic [ShiftW-1:0] symbol_shift_r, symbol_shift_nxt;
  logic [PhaseW-1:0] cell_phase_r,   cell_phase_nxt;
  logic [CntW-1:0]   bytes_scored_r, bytes_scored_nxt;
  logic [ScoreW-1:0] score_sum_r,    score_sum_nxt;

  logic [ShiftW-1:0] shift_cur;
  logic [PhaseW-1:0] phase_cur;
  logic [CntW-1:0]   cnt_cur;
  logic [ScoreW-1:0] score_cur;
  logic [ByteW-1:0]  byte_val;
  logic              byte_ready;
  logic [OnesW-1:0]  diff_ones;
  logic [SumW-1:0]   score_add;
  result_t           res_nxt;

  always_comb begin
    // A frame start clears the packer and the score before this cell counts.
    shift_cur = s1_start_r ? '0 : symbol_shift_r;
    phase_cur = s1_start_r ? '0 : cell_phase_r;
    cnt_cur   = s1_start_r ? '0 : bytes_scored_r;
    score_cur = s1_start_r ? '0 : score_sum_r;

    byte_val         = '0;
    byte_ready       = 1'b0;
    diff_ones        = '0;
    score_add        = '0;
    symbol_shift_nxt = shift_cur;
    cell_phase_nxt   = phase_cur;
    bytes_scored_nxt = cnt_cur;
    score_sum_nxt    = score_cur;

    if (phase_cur == {PhaseW{1'b1}}) begin
      byte_val         = {shift_cur, sym};
      byte_ready       = 1'b1;
      symbol_shift_nxt = '0;
      cell_phase_nxt   = '0;
      if (cnt_cur < CntW'(HEADER_BYTES)) begin
        diff_ones        = OnesW'($countones(byte_val ^ HeaderTable[3'(cnt_cur)]));
        score_add        = {1'b0, score_cur} + SumW'(diff_ones);
        // The score saturates at its all-ones value.
        score_sum_nxt    = score_add[ScoreW] ? {ScoreW{1'b1}} : score_add[ScoreW-1:0];
        bytes_scored_nxt = cnt_cur + 1'b1;
      end
    end else begin
      symbol_shift_nxt = {shift_cur[ShiftW-SymbolW-1:0], sym};
      cell_phase_nxt   = phase_cur + 1'b1;
    end

    res_nxt.cell_symbol     = sym;
    res_nxt.packed_byte     = byte_val;
    res_nxt.header_score    = score_sum_nxt;
    res_nxt.header_complete = (bytes_scored_nxt >= CntW'(HEADER_BYTES));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      symbol_shift_r <= '0;
      cell_phase_r   <= '0;
      bytes_scored_r <= '0;
      score_sum_r    <= '0;
    end else if (s1_advance) begin
      symbol_shift_r <= symbol_shift_nxt;
      cell_phase_r   <= cell_phase_nxt;
      bytes_scored_r <= bytes_scored_nxt;
      score_sum_r    <= score_sum_nxt;
    end
  end

  // Result register.
  result_t out_res_r;
  logic    out_ready_flag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_res_r        <= res_nxt;
      out_ready_flag_r <= byte_ready;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OutPadW{1'b0}}, out_res_r};
  assign out_tuser  = out_ready_flag_r;

  // Checks.
  `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, bytes_scored_r <= CntW'(HEADER_BYTES),
                 "header byte count overran")
  `ASSERT_NEXT(a_score_mono, clk, rst_n, s1_advance && !s1_start_r,
               score_sum_r >= $past(score_sum_r), "score fell within a frame")
  `ASSERT_ALWAYS(a_byte_zero, clk, rst_n,
                 !out_valid_r || out_ready_flag_r || out_res_r.packed_byte == '0,
                 "packed byte set without byte_ready")
  `ASSERT_ALWAYS(a_empty_ready, clk, rst_n, out_valid_r || in_tready,
                 "input blocked with empty result register")

endmodule

@@ sv/ccsd_nearest.sv @@
module ccsd_nearest import ccsd_pkg::*; (
  input  color_t   color,
  input  palette_t palette,
  output symbol_t  symbol
);

  // Squared Euclidean distance between two colors; at most 3 * 255^2.
  function automatic logic [DistW-1:0] sq_dist(color_t a, color_t b);
    logic signed [ColorW:0]  db;
    logic signed [ColorW:0]  dg;
    logic signed [ColorW:0]  dr;
    logic signed [DistW-1:0] sb;
    logic signed [DistW-1:0] sg;
    logic signed [DistW-1:0] sr;
    db = $signed({1'b0, a.blue})  - $signed({1'b0, b.blue});
    dg = $signed({1'b0, a.green}) - $signed({1'b0, b.green});
    dr = $signed({1'b0, a.red})   - $signed({1'b0, b.red});
    sb = db * db;
    sg = dg * dg;
    sr = dr * dr;
    return $unsigned(sb) + $unsigned(sg) + $unsigned(sr);
  endfunction

  logic [DistW-1:0] cand_dist [PaletteSize];
  logic [DistW-1:0] best_dist;
  symbol_t          best_sym;

  always_comb begin
    for (int k = 0; k < PaletteSize; k++) begin
      cand_dist[k] = sq_dist(color, palette[k]);
    end
  end

  // Strict compare keeps the lower index on a tie.
  always_comb begin
    best_dist = cand_dist[0];
    best_sym  = '0;
    for (int k = 1; k < PaletteSize; k++) begin
      if (cand_dist[k] < best_dist) begin
        best_dist = cand_dist[k];
        best_sym  = SymbolW'(k);
      end
    end
  end

  assign symbol = best_sym;

endmodule

@@ tb/color_cell_symbol_decoder_unit_tb.sv @@
module color_cell_symbol_decoder_unit_tb;
  import ccsd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One expected result transfer: the tdata fields plus the byte_ready flag in tuser.
  typedef struct packed {
    logic    byte_ready;
    result_t res;
  } cell_result_t;

  // Tracks the palette, the symbol packer and the header score the same way the
  // block should, and keeps the results it has predicted but not yet seen.
  class symbol_ledger;
    color_t         palette [PaletteSize];
    logic [5:0]     shift_reg;
    logic [1:0]     cell_phase;
    int unsigned    hdr_count;
    logic [5:0]     score;
    cell_result_t   pending_results [$];
    int unsigned    error_count;

    function new();
      foreach (palette[i]) palette[i] = '0;
      shift_reg   = '0;
      cell_phase  = '0;
      hdr_count   = 0;
      score       = '0;
      error_count = 0;
    endfunction

    function automatic int unsigned sq_dist(color_t a, color_t b);
      int dr;
      int dg;
      int db;
      dr = int'(a.red) - int'(b.red);
      dg = int'(a.green) - int'(b.green);
      db = int'(a.blue) - int'(b.blue);
      return dr * dr + dg * dg + db * db;
    endfunction

    // Predicts the result of one accepted cell transfer.
    function automatic void add_cell(color_t c, logic frame_start);
      int unsigned  best_d;
      int unsigned  d;
      int unsigned  sum;
      symbol_t      best;
      logic [7:0]   byte_v;
      cell_result_t e;
      if (frame_start) begin
        shift_reg  = '0;
        cell_phase = '0;
        hdr_count  = 0;
        score      = '0;
      end
      best   = '0;
      best_d = sq_dist(c, palette[0]);
      for (int k = 1; k < PaletteSize; k++) begin
        d = sq_dist(c, palette[k]);
        // Strictly smaller only, so the lowest index keeps a tie.
        if (d < best_d) begin
          best_d = d;
          best   = symbol_t'(k);
        end
      end
      e = '0;
      e.res.cell_symbol = best;
      if (cell_phase == 2'd3) begin
        byte_v = {shift_reg, best};
        e.byte_ready      = 1'b1;
        e.res.packed_byte = byte_v;
        shift_reg  = '0;
        cell_phase = '0;
        if (hdr_count < HeaderBytesDef) begin
          sum = int'(score) + $countones(byte_v ^ HeaderTable[hdr_count % HeaderDepth]);
          score = (sum > 63) ? 6'd63 : sum[5:0];
          hdr_count++;
        end
      end else begin
        shift_reg  = {shift_reg[3:0], best};
        cell_phase = cell_phase + 2'd1;
      end
      e.res.header_score    = score;
      e.res.header_complete = (hdr_count >= HeaderBytesDef);
      pending_results = {pending_results, e};
    endfunction

    function automatic void flag(string field, logic [7:0] want, logic [7:0] seen);
      if (seen !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, seen);
        error_count++;
      end
    endfunction

    // Compares one accepted result transfer with the oldest prediction.
    function automatic void match_result(logic [23:0] data, logic ready);
      result_t      got;
      cell_result_t exp_r;
      got = result_t'(data[$bits(result_t)-1:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, actual %h/%b",
                 $time, data, ready);
        error_count++;
        return;
      end
      exp_r = pending_results.pop_front();
      flag("cell_symbol", 8'(exp_r.res.cell_symbol), 8'(got.cell_symbol));
      flag("byte_ready", 8'(exp_r.byte_ready), 8'(ready));
      flag("packed_byte", exp_r.res.packed_byte, got.packed_byte);
      flag("header_score", 8'(exp_r.res.header_score), 8'(got.header_score));
      flag("header_complete", 8'(exp_r.res.header_complete), 8'(got.header_complete));
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [23:0]         in_tdata;
  logic                in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [23:0]         out_tdata;
  logic                out_tuser;
  logic                cfg_wr_en;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  symbol_ledger ledger;
  // When set, the sender pushes cells back to back for the whole frame.
  bit           sender_busy;
  int unsigned  random_cells;

  color_cell_symbol_decoder_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #10ms;
    $display("color_cell_symbol_decoder_unit regression: fail");
    $finish;
  end

  // Symbol n of a frame whose first bytes spell the fixed header exactly.
  function automatic symbol_t header_symbol(int unsigned n);
    logic [7:0] hdr;
    hdr = HeaderTable[(n / 4) % HeaderDepth] >> (6 - 2 * (n % 4));
    return hdr[1:0];
  endfunction

  // Moves one channel by a random amount within +/- j, clamped to the 8-bit range.
  function automatic logic [7:0] nudge(logic [7:0] ch, int unsigned j);
    int v;
    v = int'(ch) + int'($urandom_range(0, 2 * j)) - int'(j);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Presents one cell after a random idle gap and waits for its transfer. The
  // valid stays high on return, so the caller must either send the next cell or
  // drop valid in the same time step.
  task automatic send_cell(color_t c, logic frame_start);
    int unsigned r;
    int unsigned gap;
    r = $urandom_range(0, 99);
    if (sender_busy || r < 55) gap = 0;
    else if (r < 85) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 60);
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= frame_start;
    do @(posedge clk); while (!in_tready);
    ledger.add_cell(c, frame_start);
  endtask

  // Stops the sender and holds off until every predicted result has arrived.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (ledger.pending_results.size() != 0) @(posedge clk);
  endtask

  // Writes all four palette registers; only called once the block has drained.
  task automatic write_palette(palette_t colors);
    // Idle clocks past the two-stage pipeline before touching the palette.
    repeat (2) @(posedge clk);
    for (int i = 0; i < PaletteSize; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= cfg_reg_e'(i);
      cfg_data  <= colors[i];
      ledger.palette[i] = colors[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // One frame of cells. Most frames are well formed: a frame start on the first
  // cell and colors near palette entries, often spelling the header so the score
  // stays low. The rest are noise with random colors and stray frame starts.
  task automatic send_frame();
    int unsigned len;
    int unsigned jit;
    logic        tidy;
    logic        fs;
    symbol_t     sym;
    color_t      c;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 64) : $urandom_range(4, 32);
    tidy = ($urandom_range(0, 99) < 80);
    sender_busy = ($urandom_range(0, 3) == 0);
    jit = $urandom_range(0, 8);
    for (int unsigned n = 0; n < len; n++) begin
      if (tidy) begin
        if (n < 4 * HeaderBytesDef && $urandom_range(0, 3) != 0) sym = header_symbol(n);
        else sym = symbol_t'($urandom_range(0, PaletteSize - 1));
        c.red   = nudge(ledger.palette[sym].red, jit);
        c.green = nudge(ledger.palette[sym].green, jit);
        c.blue  = nudge(ledger.palette[sym].blue, jit);
        fs = (n == 0);
      end else begin
        c  = color_t'($urandom_range(0, 24'hFFFFFF));
        fs = (n == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 19) == 0);
      end
      send_cell(c, fs);
      random_cells++;
    end
  endtask

  // Result receiver: long stretches with no back-pressure, short stalls, and
  // now and then a long stall. One assignment per pass, never twice in a step.
  initial begin
    int unsigned r;
    int unsigned hold;
    logic        lvl;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        lvl  = 1'b1;
        hold = $urandom_range(20, 80);
      end else if (r < 70) begin
        lvl  = 1'b1;
        hold = $urandom_range(1, 4);
      end else if (r < 95) begin
        lvl  = 1'b0;
        hold = $urandom_range(1, 3);
      end else begin
        lvl  = 1'b0;
        hold = $urandom_range(10, 40);
      end
      out_tready <= lvl;
      repeat (hold) @(posedge clk);
    end
  end

  // Every result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) ledger.match_result(out_tdata, out_tuser);
  end

  initial begin
    palette_t    colors;
    color_t      base;
    int unsigned mode;
    ledger = new();
    sender_busy  = 1'b0;
    random_cells = 0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_PALETTE_ZERO;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Right after reset every palette entry is black, so both
    // extreme cells tie four ways and must resolve to symbol zero.
    send_cell(color_t'(24'h000000), 1'b0);
    send_cell(color_t'(24'hFFFFFF), 1'b0);
    wait_for_results();
    colors = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h0000FF};
    write_palette(colors);
    // A frame start in the middle of a group throws away the two symbols held
    // so far; the next twenty cells spell the header exactly, so the score
    // must stay at zero and the complete flag rise with the fifth byte.
    for (int unsigned n = 0; n < 4 * HeaderBytesDef; n++)
      send_cell(ledger.palette[header_symbol(n)], n == 0);
    // A byte past the header is emitted but leaves the score alone.
    send_cell(ledger.palette[2], 1'b0);
    send_cell(ledger.palette[3], 1'b0);
    send_cell(ledger.palette[2], 1'b0);
    send_cell(ledger.palette[1], 1'b0);

    // Random part in phases. Each phase drains the block, loads a new palette
    // and runs a few frames.
    while (random_cells < 1150) begin
      wait_for_results();
      mode = $urandom_range(0, 9);
      base = color_t'($urandom_range(0, 24'hFFFFFF));
      for (int i = 0; i < PaletteSize; i++) begin
        case (mode)
          0: colors[i] = '0;
          1: colors[i] = '1;
          2: begin
            // Corners of the color cube.
            colors[i].red   = {8{1'($urandom_range(0, 1))}};
            colors[i].green = {8{1'($urandom_range(0, 1))}};
            colors[i].blue  = {8{1'($urandom_range(0, 1))}};
          end
          3: begin
            // Duplicated entries make exact ties common.
            colors[i] = ($urandom_range(0, 1) != 0) ? base
                                                    : color_t'($urandom_range(0, 24'hFFFFFF));
          end
          4: begin
            // Entries close together, so small jitter flips the choice.
            colors[i].red   = nudge(base.red, 6);
            colors[i].green = nudge(base.green, 6);
            colors[i].blue  = nudge(base.blue, 6);
          end
          default: colors[i] = color_t'($urandom_range(0, 24'hFFFFFF));
        endcase
      end
      write_palette(colors);
      repeat ($urandom_range(3, 6)) send_frame();
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    if (ledger.error_count == 0 && ledger.pending_results.size() == 0) begin
      $display("color_cell_symbol_decoder_unit regression: pass");
    end else begin
      if (ledger.pending_results.size() != 0)
        $display("%0t: results still pending, expected 0, actual %0d", $time,
                 ledger.pending_results.size());
      $display("color_cell_symbol_decoder_unit regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/ccsd_pkg.sv
sv/ccsd_nearest.sv
sv/color_cell_symbol_decoder_unit.sv
tb/color_cell_symbol_decoder_unit_tb.sv
